[rtl/core/cslt_pkg.sv]
// Shared types and constants for the serial line transceiver core.
`timescale 1ns / 1ps
package cslt_pkg;

   // slot table and message memory geometry
   localparam int SLOT_COUNT = 4;
   localparam int MSG_BYTES  = 16;

   // command codes carried by an input item
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUEUE = 2'd2;
   localparam logic [1:0] CMD_REQ   = 2'd3;

   // link modes
   localparam logic [1:0] LINK_READ  = 2'd0;
   localparam logic [1:0] LINK_REQ   = 2'd1;
   localparam logic [1:0] LINK_WRITE = 2'd2;

   // slot status codes
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_QUEUED  = 2'd1;
   localparam logic [1:0] SLOT_SENDING = 2'd2;

   // register indexes
   localparam logic CSR_BACKOFF_BASE = 1'b0;
   localparam logic CSR_MAX_TRIES    = 1'b1;

   localparam logic [5:0] BACKOFF_BASE_RESET = 6'd6;
   localparam logic [4:0] MAX_TRIES_RESET    = 5'd20;

   // line framing
   localparam int          OVERSAMPLE   = 3;
   localparam logic [3:0]  DATA_BITS    = 4'd8;
   localparam logic [3:0]  STOP_BIT_POS = 4'd9;
   localparam logic [7:0]  IDLE_MAX     = 8'd255;

   // receiver phases
   typedef enum logic [2:0] {
      RX_WAIT   = 3'd0,
      RX_CONF   = 3'd1,
      RX_IGN1   = 3'd2,
      RX_IGN2   = 3'd3,
      RX_SAMPLE = 3'd4
   } rx_phase_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic       rx_level;
      logic [1:0] slot;
      logic [3:0] byte_index;
      logic [7:0] byte_value;
      logic [4:0] length;
   } req_item_type;

   typedef struct packed {
      logic       tx_drive;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       framing_error;
      logic       collision;
      logic       slot_done;
      logic [1:0] done_slot;
      logic       gave_up;
      logic [1:0] link_mode;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the item, start the message memory read
      logic execute;   // update state and load the result register
   } ctrl_cmd_type;

endpackage

[rtl/core/cslt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cslt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/cslt_ctrl.sv]
// Controller: sequences accept, execute and result hand-off.
`timescale 1ns / 1ps
module cslt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cslt_pkg::ctrl_cmd_type cmd
);

   cslt_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic exec_go;

   assign req_ready = (state_ff == cslt_pkg::ST_IDLE);
   // result register free, or emptied this cycle
   assign exec_go   = (state_ff == cslt_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = exec_go;
   assign rsp_valid   = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cslt_pkg::ST_IDLE: begin
            if (req_valid) state_in = cslt_pkg::ST_EXEC;
         end
         cslt_pkg::ST_EXEC: begin
            if (exec_go) state_in = cslt_pkg::ST_IDLE;
         end
         default: state_in = cslt_pkg::ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (exec_go) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cslt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/cslt_dp.sv]
// Datapath: receiver, transmitter, slot table, message memory, result register.
`timescale 1ns / 1ps
module cslt_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  cslt_pkg::ctrl_cmd_type cmd,
   input  cslt_pkg::req_item_type req_item,
   output cslt_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [5:0]             csr_wdata
);

   localparam int SLOT_COUNT = cslt_pkg::SLOT_COUNT;
   localparam int MSG_BYTES  = cslt_pkg::MSG_BYTES;
   localparam int SAW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int DEPTH = SLOT_COUNT * MSG_BYTES;
   localparam int AW    = $clog2(DEPTH);

   // configuration
   logic [5:0] backoff_base_ff;
   logic [4:0] max_tries_ff;

   // captured item and result
   cslt_pkg::req_item_type in_ff;
   cslt_pkg::rsp_item_type out_ff, out_in;

   // line state
   cslt_pkg::rx_phase_type rx_phase_ff, rx_phase_in;
   logic [7:0]     rx_shift_ff, rx_shift_in;
   logic [3:0]     rx_bits_ff, rx_bits_in;
   logic [1:0]     tick_phase_ff, tick_phase_in;
   logic [1:0]     link_ff, link_in;
   logic [7:0]     idle_ff, idle_in;
   logic [5:0]     try_ff, try_in;
   logic [SAW-1:0] active_ff, active_in;
   logic [4:0]     byte_pos_ff, byte_pos_in;
   logic [3:0]     bit_pos_ff, bit_pos_in;
   logic           driven_ff, driven_in;
   logic           drive_ff, drive_in;
   logic [1:0]     status_ff [SLOT_COUNT];
   logic [1:0]     status_in [SLOT_COUNT];
   logic [4:0]     length_ff [SLOT_COUNT];
   logic [4:0]     length_in [SLOT_COUNT];

   // message memory
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_rdata;
   logic [SAW-1:0] in_slot;

   assign in_slot   = SAW'(in_ff.slot);
   assign ram_waddr = AW'(32'(in_slot) * MSG_BYTES + 32'(in_ff.byte_index));
   assign ram_raddr = AW'(32'(active_ff) * MSG_BYTES + 32'(byte_pos_ff[3:0]));

   cslt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_msg_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (in_ff.byte_value),
      .rd_en   (cmd.capture),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // one item of work
   always_comb begin
      logic           found;
      logic [SAW-1:0] first_q;
      logic [8:0]     threshold;
      logic [2:0]     sh;
      logic [4:0]     next_pos;

      found     = 1'b0;
      first_q   = '0;
      threshold = '0;
      sh        = '0;
      next_pos  = '0;

      rx_phase_in   = rx_phase_ff;
      rx_shift_in   = rx_shift_ff;
      rx_bits_in    = rx_bits_ff;
      tick_phase_in = tick_phase_ff;
      link_in       = link_ff;
      idle_in       = idle_ff;
      try_in        = try_ff;
      active_in     = active_ff;
      byte_pos_in   = byte_pos_ff;
      bit_pos_in    = bit_pos_ff;
      driven_in     = driven_ff;
      drive_in      = drive_ff;
      status_in     = status_ff;
      length_in     = length_ff;
      ram_we        = 1'b0;
      out_in        = '0;

      case (in_ff.command)
         cslt_pkg::CMD_LOAD: begin
            if (32'(in_ff.slot) < SLOT_COUNT && 32'(in_ff.byte_index) < MSG_BYTES)
               ram_we = cmd.execute;
         end
         cslt_pkg::CMD_QUEUE: begin
            if (32'(in_ff.slot) < SLOT_COUNT && in_ff.length != 5'd0 &&
                32'(in_ff.length) <= MSG_BYTES &&
                status_ff[in_slot] != cslt_pkg::SLOT_SENDING) begin
               length_in[in_slot] = in_ff.length;
               status_in[in_slot] = cslt_pkg::SLOT_QUEUED;
            end
         end
         cslt_pkg::CMD_REQ: begin
            if (link_ff == cslt_pkg::LINK_READ) begin
               link_in = cslt_pkg::LINK_REQ;
               try_in  = '0;
            end
         end
         default: begin
            // tick: advance the oversampling phase
            tick_phase_in = (32'(tick_phase_ff) >= cslt_pkg::OVERSAMPLE - 1) ?
                            2'd0 : tick_phase_ff + 2'd1;

            // receiver
            case (rx_phase_ff)
               cslt_pkg::RX_CONF:
                  rx_phase_in = in_ff.rx_level ? cslt_pkg::RX_WAIT : cslt_pkg::RX_IGN1;
               cslt_pkg::RX_IGN1: rx_phase_in = cslt_pkg::RX_IGN2;
               cslt_pkg::RX_IGN2: rx_phase_in = cslt_pkg::RX_SAMPLE;
               cslt_pkg::RX_SAMPLE: begin
                  if (rx_bits_ff >= cslt_pkg::DATA_BITS) begin
                     if (in_ff.rx_level) begin
                        out_in.rx_valid = 1'b1;
                        out_in.rx_byte  = rx_shift_ff;
                     end else begin
                        out_in.framing_error = 1'b1;
                     end
                     rx_shift_in = '0;
                     rx_bits_in  = '0;
                     rx_phase_in = cslt_pkg::RX_WAIT;
                  end else begin
                     rx_phase_in = cslt_pkg::RX_IGN1;
                     rx_shift_in = {in_ff.rx_level, rx_shift_ff[7:1]};
                     rx_bits_in  = rx_bits_ff + 4'd1;
                  end
               end
               default: begin
                  rx_phase_in = cslt_pkg::RX_WAIT;
                  if (link_ff != cslt_pkg::LINK_WRITE && !in_ff.rx_level) begin
                     idle_in     = '0;
                     rx_phase_in = cslt_pkg::RX_CONF;
                  end
               end
            endcase

            // transmitter, once per bit time
            if (tick_phase_in == 2'd0) begin
               if (link_in == cslt_pkg::LINK_READ) drive_in = 1'b0;

               if (in_ff.rx_level && link_in == cslt_pkg::LINK_REQ) begin
                  if (idle_in != cslt_pkg::IDLE_MAX) idle_in = idle_in + 8'd1;
                  threshold = {3'b0, backoff_base_ff} + {4'b0, max_tries_ff} - {3'b0, try_in};
                  if (try_in > {1'b0, max_tries_ff}) begin
                     link_in        = cslt_pkg::LINK_READ;
                     out_in.gave_up = 1'b1;
                  end else if ({1'b0, idle_in} > threshold) begin
                     // first queued slot, lowest index wins
                     for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                        if (status_ff[i] == cslt_pkg::SLOT_QUEUED) begin
                           found   = 1'b1;
                           first_q = SAW'(i);
                        end
                     end
                     if (found) begin
                        status_in[first_q] = cslt_pkg::SLOT_SENDING;
                        active_in   = first_q;
                        try_in      = try_in + 6'd1;
                        link_in     = cslt_pkg::LINK_WRITE;
                        byte_pos_in = '0;
                        bit_pos_in  = '0;
                        driven_in   = 1'b1;
                     end else begin
                        link_in = cslt_pkg::LINK_READ;
                     end
                  end
               end

               if (link_in == cslt_pkg::LINK_WRITE) begin
                  if (driven_in != in_ff.rx_level) begin
                     // collision: back off and requeue
                     out_in.collision     = 1'b1;
                     byte_pos_in          = '0;
                     bit_pos_in           = '0;
                     link_in              = cslt_pkg::LINK_REQ;
                     status_in[active_in] = cslt_pkg::SLOT_QUEUED;
                  end else if (bit_pos_in == 4'd0) begin
                     driven_in  = 1'b0;
                     bit_pos_in = 4'd1;
                  end else if (bit_pos_in == cslt_pkg::STOP_BIT_POS) begin
                     driven_in   = 1'b1;
                     bit_pos_in  = '0;
                     next_pos    = byte_pos_in + 5'd1;
                     byte_pos_in = next_pos;
                     if (length_ff[active_in] == next_pos) begin
                        status_in[active_in] = cslt_pkg::SLOT_FREE;
                        link_in              = cslt_pkg::LINK_READ;
                        out_in.slot_done     = 1'b1;
                        out_in.done_slot     = 2'(active_in);
                     end
                  end else begin
                     sh         = 3'(bit_pos_in - 4'd1);
                     driven_in  = (bit_pos_in > cslt_pkg::STOP_BIT_POS) ? 1'b0 : ram_rdata[sh];
                     bit_pos_in = bit_pos_in + 4'd1;
                  end
                  drive_in = ~driven_in;
               end
            end
         end
      endcase

      out_in.tx_drive  = drive_in;
      out_in.link_mode = link_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         backoff_base_ff <= cslt_pkg::BACKOFF_BASE_RESET;
         max_tries_ff    <= cslt_pkg::MAX_TRIES_RESET;
         rx_phase_ff     <= cslt_pkg::RX_WAIT;
         rx_shift_ff     <= '0;
         rx_bits_ff      <= '0;
         tick_phase_ff   <= '0;
         link_ff         <= cslt_pkg::LINK_READ;
         idle_ff         <= '0;
         try_ff          <= '0;
         active_ff       <= '0;
         byte_pos_ff     <= '0;
         bit_pos_ff      <= '0;
         driven_ff       <= 1'b1;
         drive_ff        <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) status_ff[i] <= cslt_pkg::SLOT_FREE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cslt_pkg::CSR_BACKOFF_BASE: backoff_base_ff <= csr_wdata;
               cslt_pkg::CSR_MAX_TRIES:    max_tries_ff    <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (cmd.execute) begin
            rx_phase_ff   <= rx_phase_in;
            rx_shift_ff   <= rx_shift_in;
            rx_bits_ff    <= rx_bits_in;
            tick_phase_ff <= tick_phase_in;
            link_ff       <= link_in;
            idle_ff       <= idle_in;
            try_ff        <= try_in;
            active_ff     <= active_in;
            byte_pos_ff   <= byte_pos_in;
            bit_pos_ff    <= bit_pos_in;
            driven_ff     <= driven_in;
            drive_ff      <= drive_in;
            status_ff     <= status_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_item;
      if (cmd.execute) begin
         out_ff    <= out_in;
         length_ff <= length_in;
      end
   end

   assign rsp_item = out_ff;

endmodule

[rtl/core/csma_cd_serial_line_transceiver_core.sv]
// Top level of the serial line transceiver core.
// A result is registered in the execute state after its item is accepted.
// A new item is taken only once the last one has executed, as the bit being sent
// needs the registered read of the message memory.
// The next item is taken while a result waits; execution holds until it is taken.
// Reset (synchronous, active high) sets receiver idle, read mode, all slots free.
`timescale 1ns / 1ps
module csma_cd_serial_line_transceiver_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cslt_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cslt_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [5:0]             csr_wdata
);

   cslt_pkg::ctrl_cmd_type cmd;

   cslt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cslt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

[rtl/core/cslt_checker.sv]
// Port-level checks for the transceiver core, bound to the top level.
`timescale 1ns / 1ps
module cslt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cslt_pkg::rsp_item_type rsp_item
);

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // a byte cannot be both good and badly framed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.rx_valid && rsp_item.framing_error))
      else $error("rx_valid with framing_error");

   // a finished message returns the link to read mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.slot_done |-> rsp_item.link_mode == cslt_pkg::LINK_READ)
      else $error("slot_done outside read mode");

   // giving up returns to read mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.gave_up |-> rsp_item.link_mode == cslt_pkg::LINK_READ)
      else $error("gave_up outside read mode");

   // a collision falls back to write requested
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.collision |->
         rsp_item.link_mode == cslt_pkg::LINK_REQ && !rsp_item.slot_done)
      else $error("collision with wrong link mode");

endmodule

bind csma_cd_serial_line_transceiver_core cslt_checker u_cslt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

[tb/csma_cd_serial_line_transceiver_core_tb.sv]
// Self-checking testbench for the serial line transceiver core: predictor, stimulus and checks.
`timescale 1ns / 1ps
module csma_cd_serial_line_transceiver_core_tb;

   localparam int NSLOT = cslt_pkg::SLOT_COUNT;
   localparam int NBYTE = cslt_pkg::MSG_BYTES;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   cslt_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   cslt_pkg::rsp_item_type rsp_item;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [5:0] csr_wdata = '0;

   csma_cd_serial_line_transceiver_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // line model state
   logic [5:0] m_backoff;
   logic [4:0] m_max_tries;
   cslt_pkg::rx_phase_type m_rx_phase;
   logic [7:0] m_rx_shift;
   logic [3:0] m_rx_bits;
   logic [1:0] m_tick_phase;
   logic [1:0] m_link;
   logic [7:0] m_idle;
   logic [5:0] m_tries;
   logic [1:0] m_active;
   logic [4:0] m_byte_pos;
   logic [3:0] m_bit_pos;
   logic m_driven;
   logic m_drive;
   logic [1:0] m_status [NSLOT];
   logic [4:0] m_length [NSLOT];
   logic [7:0] m_bytes [NSLOT][NBYTE];

   cslt_pkg::rsp_item_type expected_rsps[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit long_gaps = 1'b1;

   // advance the line model by one item, return the result it produces
   function automatic cslt_pkg::rsp_item_type line_step(cslt_pkg::req_item_type it);
      cslt_pkg::rsp_item_type r;
      int i;
      int thr;
      r = '0;
      case (it.command)
         cslt_pkg::CMD_LOAD: m_bytes[it.slot][it.byte_index] = it.byte_value;
         cslt_pkg::CMD_QUEUE: begin
            if (it.length >= 1 && it.length <= NBYTE &&
                m_status[it.slot] != cslt_pkg::SLOT_SENDING) begin
               m_length[it.slot] = it.length;
               m_status[it.slot] = cslt_pkg::SLOT_QUEUED;
            end
         end
         cslt_pkg::CMD_REQ: begin
            if (m_link == cslt_pkg::LINK_READ) begin
               m_link = cslt_pkg::LINK_REQ;
               m_tries = '0;
            end
         end
         default: begin
            m_tick_phase = (m_tick_phase == 2'd2) ? 2'd0 : m_tick_phase + 2'd1;
            // receiver
            case (m_rx_phase)
               cslt_pkg::RX_CONF:
                  m_rx_phase = it.rx_level ? cslt_pkg::RX_WAIT : cslt_pkg::RX_IGN1;
               cslt_pkg::RX_IGN1: m_rx_phase = cslt_pkg::RX_IGN2;
               cslt_pkg::RX_IGN2: m_rx_phase = cslt_pkg::RX_SAMPLE;
               cslt_pkg::RX_SAMPLE: begin
                  if (m_rx_bits >= 4'd8) begin
                     if (it.rx_level) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = m_rx_shift;
                     end else r.framing_error = 1'b1;
                     m_rx_shift = '0;
                     m_rx_bits = '0;
                     m_rx_phase = cslt_pkg::RX_WAIT;
                  end else begin
                     m_rx_phase = cslt_pkg::RX_IGN1;
                     m_rx_shift = {it.rx_level, m_rx_shift[7:1]};
                     m_rx_bits++;
                  end
               end
               default: begin
                  m_rx_phase = cslt_pkg::RX_WAIT;
                  if (m_link != cslt_pkg::LINK_WRITE && !it.rx_level) begin
                     m_idle = '0;
                     m_rx_phase = cslt_pkg::RX_CONF;
                  end
               end
            endcase
            // transmitter, once per bit time
            if (m_tick_phase == 2'd0) begin
               if (m_link == cslt_pkg::LINK_READ) m_drive = 1'b0;
               if (it.rx_level && m_link == cslt_pkg::LINK_REQ) begin
                  if (m_idle != 8'd255) m_idle++;
                  thr = int'(m_backoff) + int'(m_max_tries) - int'(m_tries);
                  if (m_tries > m_max_tries) begin
                     m_link = cslt_pkg::LINK_READ;
                     r.gave_up = 1'b1;
                  end else if (int'(m_idle) > thr) begin
                     for (i = 0; i < NSLOT; i++)
                        if (m_status[i] == cslt_pkg::SLOT_QUEUED) break;
                     if (i < NSLOT) begin
                        m_status[i] = cslt_pkg::SLOT_SENDING;
                        m_active = 2'(i);
                        m_tries++;
                        m_link = cslt_pkg::LINK_WRITE;
                        m_byte_pos = '0;
                        m_bit_pos = '0;
                        m_driven = 1'b1;
                     end else m_link = cslt_pkg::LINK_READ;
                  end
               end
               if (m_link == cslt_pkg::LINK_WRITE) begin
                  if (m_driven != it.rx_level) begin
                     r.collision = 1'b1;
                     m_byte_pos = '0;
                     m_bit_pos = '0;
                     m_link = cslt_pkg::LINK_REQ;
                     m_status[m_active] = cslt_pkg::SLOT_QUEUED;
                  end else if (m_bit_pos == 4'd0) begin
                     m_driven = 1'b0;
                     m_bit_pos = 4'd1;
                  end else if (m_bit_pos == 4'd9) begin
                     m_driven = 1'b1;
                     m_bit_pos = '0;
                     m_byte_pos++;
                     if (m_length[m_active] == m_byte_pos) begin
                        m_status[m_active] = cslt_pkg::SLOT_FREE;
                        m_link = cslt_pkg::LINK_READ;
                        r.slot_done = 1'b1;
                        r.done_slot = m_active;
                     end
                  end else begin
                     m_driven = m_bytes[m_active][m_byte_pos[3:0]][m_bit_pos - 4'd1];
                     m_bit_pos++;
                  end
                  m_drive = ~m_driven;
               end
            end
         end
      endcase
      r.tx_drive = m_drive;
      r.link_mode = m_link;
      return r;
   endfunction

   function automatic int gap_len();
      if (!long_gaps || $urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 20);
      return $urandom_range(1, 3);
   endfunction

   // send one item: model it, then hold valid until accepted
   // valid stays high after acceptance until a gap or wait_drained drops it
   task automatic send_item(cslt_pkg::req_item_type it);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      expected_rsps.push_back(line_step(it));
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_tick(logic lvl);
      cslt_pkg::req_item_type it;
      it = '0;
      it.command = cslt_pkg::CMD_TICK;
      it.rx_level = lvl;
      it.slot = 2'($urandom);
      it.byte_value = 8'($urandom);
      send_item(it);
   endtask

   task automatic send_load(logic [1:0] s, logic [3:0] idx, logic [7:0] v);
      cslt_pkg::req_item_type it;
      it = '0;
      it.command = cslt_pkg::CMD_LOAD;
      it.slot = s;
      it.byte_index = idx;
      it.byte_value = v;
      it.rx_level = 1'($urandom);
      send_item(it);
   endtask

   task automatic send_queue(logic [1:0] s, logic [4:0] len);
      cslt_pkg::req_item_type it;
      it = '0;
      it.command = cslt_pkg::CMD_QUEUE;
      it.slot = s;
      it.length = len;
      send_item(it);
   endtask

   task automatic send_request();
      cslt_pkg::req_item_type it;
      it = cslt_pkg::req_item_type'($urandom);
      it.command = cslt_pkg::CMD_REQ;
      send_item(it);
   endtask

   // bit time of line level, three samples
   task automatic send_bit(logic lvl);
      repeat (3) send_tick(lvl);
   endtask

   // serial frame onto the line, optional bad stop bit
   task automatic send_frame(logic [7:0] v, logic stop);
      send_bit(1'b0);
      for (int i = 0; i < 8; i++) send_bit(v[i]);
      send_bit(stop);
      send_bit(1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [5:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == cslt_pkg::CSR_BACKOFF_BASE) m_backoff = v;
      else m_max_tries = v[4:0];
   endtask

   // loads every slot byte so no unwritten byte is ever sent
   task automatic test_load_all();
      for (int s = 0; s < NSLOT; s++)
         for (int b = 0; b < NBYTE; b++)
            send_load(2'(s), 4'(b), (s == 0 && b == 0) ? 8'hff : 8'h00);
   endtask

   // receive good, bad-stop and extreme bytes; ignored queue lengths
   task automatic test_receive();
      send_frame(8'h00, 1'b1);
      send_frame(8'hff, 1'b1);
      send_frame(8'ha5, 1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_queue(2'd1, 5'd0);
      send_queue(2'd1, 5'd17);
      send_queue(2'd1, 5'd31);
   endtask

   // transmit with a line that echoes the drive; optional collision
   task automatic run_link(int ticks, int coll_pct);
      logic lvl;
      for (int i = 0; i < ticks; i++) begin
         lvl = ~m_drive;
         if ($urandom_range(0, 99) < coll_pct) lvl = ~lvl;
         send_tick(lvl);
      end
   endtask

   task automatic test_transmit(int rounds);
      for (int r = 0; r < rounds; r++) begin
         if ($urandom_range(0, 1)) send_load(2'($urandom), 4'($urandom), 8'($urandom));
         send_queue(2'($urandom), 5'($urandom_range(1, 2)));
         if ($urandom_range(0, 3) == 0) send_queue(2'($urandom), 5'd16);
         send_request();
         send_request();
         run_link($urandom_range(20, 120), $urandom_range(0, 3) == 0 ? 8 : 0);
      end
   endtask

   // give up: constant collisions
   task automatic test_give_up();
      send_queue(2'd2, 5'd1);
      send_request();
      while (m_link != cslt_pkg::LINK_READ)
         send_tick(m_link == cslt_pkg::LINK_WRITE ? m_drive : 1'b1);
   endtask

   task automatic test_noise(int n);
      cslt_pkg::req_item_type it;
      for (int i = 0; i < n; i++) begin
         it = cslt_pkg::req_item_type'($urandom);
         if (it.command == cslt_pkg::CMD_QUEUE &&
             m_status[it.slot] != cslt_pkg::SLOT_SENDING &&
             it.length >= 1 && it.length <= NBYTE) it.length = 5'd1;
         send_item(it);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      cslt_pkg::rsp_item_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result %h", rsp_item);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_item !== exp_rsp) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %p actual %p", exp_rsp, rsp_item);
               end
            end
         end
         rsp_ready <= (!long_gaps || $urandom_range(0, 3) != 0) ? 1'b1
                    : ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else if (req_valid || expected_rsps.size() != 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL csma_cd_serial_line_transceiver_core");
         $finish;
      end
   end

   initial begin
      m_backoff = cslt_pkg::BACKOFF_BASE_RESET;
      m_max_tries = cslt_pkg::MAX_TRIES_RESET;
      m_rx_phase = cslt_pkg::RX_WAIT;
      m_rx_shift = '0;
      m_rx_bits = '0;
      m_tick_phase = '0;
      m_link = cslt_pkg::LINK_READ;
      m_idle = '0;
      m_tries = '0;
      m_active = '0;
      m_byte_pos = '0;
      m_bit_pos = '0;
      m_driven = 1'b1;
      m_drive = 1'b0;
      for (int s = 0; s < NSLOT; s++) begin
         m_status[s] = cslt_pkg::SLOT_FREE;
         m_length[s] = '0;
         for (int b = 0; b < NBYTE; b++) m_bytes[s][b] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_all();
      test_receive();
      write_reg(cslt_pkg::CSR_BACKOFF_BASE, 6'd0);
      write_reg(cslt_pkg::CSR_MAX_TRIES, 6'd1);
      test_transmit(2);
      test_give_up();
      long_gaps = 1'b0;
      test_transmit(2);
      long_gaps = 1'b1;
      write_reg(cslt_pkg::CSR_BACKOFF_BASE, 6'd63);
      write_reg(cslt_pkg::CSR_MAX_TRIES, 6'd31);
      test_transmit(1);
      write_reg(cslt_pkg::CSR_BACKOFF_BASE, 6'd2);
      write_reg(cslt_pkg::CSR_MAX_TRIES, 6'd3);
      test_transmit(4);
      test_noise(150);
      wait_drained();
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("PASS csma_cd_serial_line_transceiver_core");
      else
         $display("FAIL csma_cd_serial_line_transceiver_core");
      $finish;
   end

endmodule

[sim.f]
rtl/core/cslt_pkg.sv
rtl/core/cslt_ram.sv
rtl/core/cslt_ctrl.sv
rtl/core/cslt_dp.sv
rtl/core/csma_cd_serial_line_transceiver_core.sv
rtl/core/cslt_checker.sv
tb/csma_cd_serial_line_transceiver_core_tb.sv
